### rtl/core/etdd_pkg.sv
`default_nettype none

package etdd_pkg;

  // field and register widths
  localparam int ECHO_W         = 16;
  localparam int CFG_W          = 10;
  localparam int CFG_IDX_W      = 2;
  localparam int COUNT_BITS_DEF = 16;
  localparam int SEG_W          = 8;

  // range limits are kept pre-scaled to product units (0.0001 cm)
  localparam int LIM_W = 24;
  localparam logic [LIM_W-1:0] CM_TO_LIM = 24'd10000;

  // compare width, enough for the widest product (16 count bits by 10 scale bits)
  localparam int PROD_W = 34;

  // tenths of a cm, at most 10230 when in range
  localparam int TENTHS_W = 14;

  // floor(p / 1000) = (p * RECIP_1000) >> 34, exact for p below 2**24
  localparam int RECIP_1000_W = 25;
  localparam logic [RECIP_1000_W-1:0] RECIP_1000 = 25'd17179870;
  localparam int RECIP_1000_SH = 34;

  // digit split reciprocals, exact for values below 2**14
  localparam logic [13:0] RECIP_10   = 14'd13108;
  localparam int          RECIP_10_SH   = 17;
  localparam logic [13:0] RECIP_100  = 14'd10486;
  localparam int          RECIP_100_SH  = 20;
  localparam logic [14:0] RECIP_K    = 15'd16778;
  localparam int          RECIP_K_SH    = 24;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX   = 2'd2;

  // register reset values
  localparam logic [CFG_W-1:0] SCALE_RST   = 10'd172;
  localparam logic [LIM_W-1:0] MIN_LIM_RST = 24'd20000;
  localparam logic [LIM_W-1:0] MAX_LIM_RST = 24'd4000000;

  typedef logic [SEG_W-1:0] seg_t;

  // display codes, active low
  localparam seg_t SEG_BLANK = 8'hFF;
  localparam seg_t SEG_DOT   = 8'h7F;
  localparam seg_t ERR_SEG_0 = 8'h86;
  localparam seg_t ERR_SEG_1 = 8'h86;
  localparam seg_t ERR_SEG_2 = 8'h88;
  localparam seg_t ERR_SEG_3 = 8'hC0;

  // live configuration handed to the datapath
  typedef struct packed {
    logic [CFG_W-1:0] scale;
    logic [LIM_W-1:0] min_lim;
    logic [LIM_W-1:0] max_lim;
  } cfg_t;

  // plain digit to segment code, decimal point dark
  function automatic seg_t seg_plain(input logic [3:0] d);
    seg_t s;
    case (d)
      4'd0:    s = 8'hC0;
      4'd1:    s = 8'hF9;
      4'd2:    s = 8'hA4;
      4'd3:    s = 8'hB0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hF8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h90;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

### rtl/core/echo_time_to_distance_display_core.sv
`default_nettype none

// Echo-time to distance display. Each word carries one echo width in timer
// counts (low COUNT_BITS bits used) and a timer-overflow flag; the result word
// carries four active-low seven-segment codes (hundreds, tens, units with the
// decimal point, tenths of a cm) and a range error flag that selects the fixed
// "EEAO" pattern. The block takes one word per clock while in_stall is low
// and holds its result while out_stall is high. An input register, the
// count-by-scale multiply with the range check, the divide by 1000 done as a
// reciprocal multiply, and the digit split with segment encoding each take
// one stage. Configuration writes go to scale_per_count (0), min_cm (1) and
// max_cm (2) and should only happen while no word is in flight.
module echo_time_to_distance_display_core #(
  parameter int COUNT_BITS = etdd_pkg::COUNT_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // configuration
  input  wire logic                           cfg_we,
  input  wire logic [etdd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [etdd_pkg::CFG_W-1:0]     cfg_wdata,
  // input words
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [etdd_pkg::ECHO_W-1:0]    in_echo_count,
  input  wire logic                           in_timer_overflow,
  // result words
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [etdd_pkg::SEG_W-1:0]          out_seg_hundreds,
  output logic [etdd_pkg::SEG_W-1:0]          out_seg_tens,
  output logic [etdd_pkg::SEG_W-1:0]          out_seg_units,
  output logic [etdd_pkg::SEG_W-1:0]          out_seg_tenths,
  output logic                                out_range_error
);
  import etdd_pkg::*;

  cfg_t              cfg;
  logic              v0_r, v1_r, v2_r, v3_r;
  logic              free0, free1, free2, free3;
  logic [ECHO_W-1:0] echo_r;
  logic              ovf_r;
  logic [LIM_W-1:0]  prod_r;
  logic              err1_r;
  logic [TENTHS_W-1:0] tenths_r;
  logic              err2_r;

  etdd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // stage occupancy, a stage can load when empty or when it moves on
  assign free3 = !v3_r || !out_stall;
  assign free2 = !v2_r || free3;
  assign free1 = !v1_r || free2;
  assign free0 = !v0_r || free1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (free0) v0_r <= in_valid;
      if (free1) v1_r <= v0_r;
      if (free2) v2_r <= v1_r;
      if (free3) v3_r <= v2_r;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (free0 && in_valid) begin
      echo_r <= in_echo_count;
      ovf_r  <= in_timer_overflow;
    end
  end

  etdd_scale #(
    .COUNT_BITS (COUNT_BITS)
  ) u_scale (
    .clk    (clk),
    .ld     (free1 && v0_r),
    .echo   (echo_r),
    .ovf    (ovf_r),
    .cfg    (cfg),
    .prod_r (prod_r),
    .err_r  (err1_r)
  );

  etdd_tenths u_tenths (
    .clk      (clk),
    .ld       (free2 && v1_r),
    .prod     (prod_r),
    .err      (err1_r),
    .tenths_r (tenths_r),
    .err_r    (err2_r)
  );

  etdd_digits u_digits (
    .clk     (clk),
    .ld      (free3 && v2_r),
    .tenths  (tenths_r),
    .err     (err2_r),
    .seg_h_r (out_seg_hundreds),
    .seg_t_r (out_seg_tens),
    .seg_u_r (out_seg_units),
    .seg_f_r (out_seg_tenths),
    .err_r   (out_range_error)
  );

  assign in_stall  = !free0;
  assign out_valid = v3_r;

  // error words carry the fixed pattern
  a_err_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_error |->
      out_seg_hundreds == ERR_SEG_0 && out_seg_tens == ERR_SEG_1 &&
      out_seg_units == ERR_SEG_2 && out_seg_tenths == ERR_SEG_3)
    else $error("error word without error pattern");

  // good words always light the decimal point
  a_dot_lit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_range_error |-> out_seg_units[SEG_W-1] == 1'b0)
    else $error("decimal point dark on good word");

  // tens is never blanked under a shown hundreds digit
  a_blanking: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_range_error && out_seg_hundreds != SEG_BLANK |->
      out_seg_tens != SEG_BLANK)
    else $error("tens blanked under hundreds");

  // input only stalls when every stage holds a word
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v0_r && v1_r && v2_r && v3_r)
    else $error("input stalled with a free stage");

endmodule

`default_nettype wire

### rtl/core/etdd_cfg_regs.sv
`default_nettype none

module etdd_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [etdd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [etdd_pkg::CFG_W-1:0]     cfg_wdata,
  output etdd_pkg::cfg_t                      cfg
);
  import etdd_pkg::*;

  logic [CFG_W-1:0] scale_r;
  logic [LIM_W-1:0] min_lim_r;
  logic [LIM_W-1:0] max_lim_r;
  logic [LIM_W-1:0] lim_nxt;

  // whole cm to product units, constant multiply
  assign lim_nxt = {{(LIM_W-CFG_W){1'b0}}, cfg_wdata} * CM_TO_LIM;

  // register file, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r   <= SCALE_RST;
      min_lim_r <= MIN_LIM_RST;
      max_lim_r <= MAX_LIM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCALE: scale_r   <= cfg_wdata;
        REG_MIN:   min_lim_r <= lim_nxt;
        REG_MAX:   max_lim_r <= lim_nxt;
        default: begin
        end
      endcase
    end
  end

  assign cfg.scale   = scale_r;
  assign cfg.min_lim = min_lim_r;
  assign cfg.max_lim = max_lim_r;

endmodule

`default_nettype wire

### rtl/core/etdd_scale.sv
`default_nettype none

module etdd_scale #(
  parameter int COUNT_BITS = etdd_pkg::COUNT_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        ld,
  input  wire logic [etdd_pkg::ECHO_W-1:0] echo,
  input  wire logic                        ovf,
  input  wire etdd_pkg::cfg_t              cfg,
  output logic [etdd_pkg::LIM_W-1:0]       prod_r,
  output logic                             err_r
);
  import etdd_pkg::*;

  localparam int USE_W = (COUNT_BITS < ECHO_W) ? COUNT_BITS : ECHO_W;
  localparam int MUL_W = USE_W + CFG_W;

  logic [USE_W-1:0]  count;
  logic [MUL_W-1:0]  prod_mul;
  logic [PROD_W-1:0] prod_ext;
  logic              err_nxt;

  // only the low count bits take part
  assign count    = echo[USE_W-1:0];
  assign prod_mul = {{CFG_W{1'b0}}, count} * {{USE_W{1'b0}}, cfg.scale};
  assign prod_ext = {{(PROD_W-MUL_W){1'b0}}, prod_mul};

  // range check against pre-scaled limits
  assign err_nxt = ovf
    || (prod_ext > {{(PROD_W-LIM_W){1'b0}}, cfg.max_lim})
    || (prod_ext < {{(PROD_W-LIM_W){1'b0}}, cfg.min_lim});

  // an in-range product always fits the low limit bits
  always_ff @(posedge clk) begin
    if (ld) begin
      prod_r <= prod_ext[LIM_W-1:0];
      err_r  <= err_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/etdd_tenths.sv
`default_nettype none

module etdd_tenths (
  input  wire logic                       clk,
  input  wire logic                       ld,
  input  wire logic [etdd_pkg::LIM_W-1:0] prod,
  input  wire logic                       err,
  output logic [etdd_pkg::TENTHS_W-1:0]   tenths_r,
  output logic                            err_r
);
  import etdd_pkg::*;

  localparam int RM_W = LIM_W + RECIP_1000_W;

  logic [RM_W-1:0] recip_prod;

  // divide by 1000 through the reciprocal
  assign recip_prod = {{RECIP_1000_W{1'b0}}, prod} * {{LIM_W{1'b0}}, RECIP_1000};

  always_ff @(posedge clk) begin
    if (ld) begin
      tenths_r <= recip_prod[RECIP_1000_SH +: TENTHS_W];
      err_r    <= err;
    end
  end

endmodule

`default_nettype wire

### rtl/core/etdd_digits.sv
`default_nettype none

module etdd_digits (
  input  wire logic                          clk,
  input  wire logic                          ld,
  input  wire logic [etdd_pkg::TENTHS_W-1:0] tenths,
  input  wire logic                          err,
  output etdd_pkg::seg_t                     seg_h_r,
  output etdd_pkg::seg_t                     seg_t_r,
  output etdd_pkg::seg_t                     seg_u_r,
  output etdd_pkg::seg_t                     seg_f_r,
  output logic                               err_r
);
  import etdd_pkg::*;

  logic [27:0] m10;
  logic [27:0] m100;
  logic [28:0] mk;
  logic [10:0] q10;
  logic [7:0]  q100;
  logic [4:0]  qk;
  logic [13:0] r_f;
  logic [10:0] r_u;
  logic [7:0]  r_t;
  logic [3:0]  d_h;
  logic [3:0]  d_t;
  logic [3:0]  d_u;
  logic [3:0]  d_f;
  seg_t        seg_h_nxt;
  seg_t        seg_t_nxt;
  seg_t        seg_u_nxt;
  seg_t        seg_f_nxt;

  // quotients by 10, 100 and 1000
  assign m10  = {14'd0, tenths} * {14'd0, RECIP_10};
  assign m100 = {14'd0, tenths} * {14'd0, RECIP_100};
  assign mk   = {15'd0, tenths} * {14'd0, RECIP_K};
  assign q10  = m10[RECIP_10_SH +: 11];
  assign q100 = m100[RECIP_100_SH +: 8];
  assign qk   = mk[RECIP_K_SH +: 5];

  // remainders give the decimal digits
  assign r_f = tenths - {q10, 3'd0} - {2'd0, q10, 1'b0};
  assign r_u = q10 - {q100[7:0], 3'd0} - {2'd0, q100, 1'b0};
  assign r_t = q100 - {qk, 3'd0} - {2'd0, qk, 1'b0};
  assign d_f = r_f[3:0];
  assign d_u = r_u[3:0];
  assign d_t = r_t[3:0];
  assign d_h = qk[3:0];

  // segment codes, leading zeros blanked, error pattern on top
  always_comb begin
    if (err) begin
      seg_h_nxt = ERR_SEG_0;
      seg_t_nxt = ERR_SEG_1;
      seg_u_nxt = ERR_SEG_2;
      seg_f_nxt = ERR_SEG_3;
    end else begin
      seg_h_nxt = (d_h == 4'd0) ? SEG_BLANK : seg_plain(d_h);
      seg_t_nxt = (d_h == 4'd0 && d_t == 4'd0) ? SEG_BLANK : seg_plain(d_t);
      seg_u_nxt = seg_plain(d_u) & SEG_DOT;
      seg_f_nxt = seg_plain(d_f);
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      seg_h_r <= seg_h_nxt;
      seg_t_r <= seg_t_nxt;
      seg_u_r <= seg_u_nxt;
      seg_f_r <= seg_f_nxt;
      err_r   <= err;
    end
  end

endmodule

`default_nettype wire
